/* hdl/rhca_pkg.sv */
// Shared types, constants and the key hash for the refcounted hash cache.
// No dependencies; every other file but rhca_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none
package rhca_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int REF_BITS    = 16;
  localparam int HANDLE_W    = 10;
  localparam int CNT_W       = 11;
  localparam int AGE_W       = 18;

  localparam logic [31:0] HASH_SEED  = 32'd177573;
  localparam logic [15:0] AGE_RESET  = 16'd600;
  localparam logic [62:0] BYTES_RESET = 63'd1000000000;
  localparam logic [15:0] FILES_RESET = 16'd2000;

  // floor(x/3) for x < 2^19 and floor(x/10) for x < 2^16 by reciprocal
  localparam logic [17:0] DIV3_MUL  = 18'd174763;
  localparam logic [15:0] DIV10_MUL = 16'd52429;

  typedef enum logic [1:0] {
    ACT_MAP   = 2'd0,
    ACT_UNMAP = 2'd1,
    ACT_CLEAN = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_ZERO      = 3'd4,
    ST_CLEANED   = 3'd5,
    ST_OVERFLOW  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CFG_AGE   = 2'd0,
    CFG_BYTES = 2'd1,
    CFG_FILES = 2'd2
  } cfg_index_t;

  typedef struct packed {
    action_t              action;
    logic [63:0]          inode;
    logic [31:0]          device;
    logic [62:0]          size;
    logic [62:0]          ctime;
    logic [62:0]          now;
    logic [HANDLE_W-1:0]  handle;
    logic [SLOT_W-1:0]    home;
  } item_t;

  typedef struct packed {
    status_t              status;
    logic [HANDLE_W-1:0]  handle;
    logic [CNT_W-1:0]     evicted;
    logic [CNT_W-1:0]     active;
    logic [63:0]          bytes;
    logic [AGE_W-1:0]     age;
  } result_t;

  typedef struct packed {
    logic                 valid;
    logic [63:0]          inode;
    logic [31:0]          device;
    logic [62:0]          size;
    logic [62:0]          ctime;
    logic [REF_BITS-1:0]  refs;
    logic [62:0]          last;
  } entry_t;

  function automatic logic [31:0] key_hash(input logic [63:0] ino, input logic [31:0] dev,
                                           input logic [62:0] size, input logic [62:0] ct);
    logic [31:0] h;
    h = HASH_SEED ^ ino[31:0];
    h = h + (h << 5);
    h = h ^ dev;
    h = h + (h << 5);
    h = h ^ size[31:0];
    h = h + (h << 5);
    h = h ^ ct[31:0];
    return h;
  endfunction

endpackage
`default_nettype wire

/* hdl/rhca_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rhca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/rhca_front.sv */
// Front end: takes request transactions, hashes the key, and holds them
// in a two-entry issue queue for the back end. Depends on rhca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rhca_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [1:0]                     action,
  input  wire logic [63:0]                    file_inode,
  input  wire logic [31:0]                    file_device,
  input  wire logic [62:0]                    file_size,
  input  wire logic [62:0]                    change_time,
  input  wire logic [62:0]                    now_seconds,
  input  wire logic [rhca_pkg::HANDLE_W-1:0]  slot_handle,
  input  wire logic                           busy,
  input  wire logic                           q_pop,
  output logic                                q_empty,
  output rhca_pkg::item_t                     q_item
);
  import rhca_pkg::*;

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [31:0] hash;
  item_t       item_in;
  logic        accept;

  assign hash = key_hash(file_inode, file_device, file_size, change_time);

  always_comb begin
    item_in.action = action_t'(action);
    item_in.inode  = file_inode;
    item_in.device = file_device;
    item_in.size   = file_size;
    item_in.ctime  = change_time;
    item_in.now    = now_seconds;
    item_in.handle = slot_handle;
    item_in.home   = hash[SLOT_W-1:0];
  end

  assign full    = (count == 2'd2) || busy;
  assign accept  = push && !full;
  assign q_empty = (count == 2'd0);
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= item_in;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (q_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, accept} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

/* hdl/rhca_outq.sv */
// Two-entry result queue between the back end and the result ports.
// Depends on rhca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rhca_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  rhca_pkg::result_t      wr_data,
  output logic                   q_full,
  input  wire logic              pop,
  output logic                   empty,
  output rhca_pkg::result_t      head
);
  import rhca_pkg::*;

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign q_full = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign head   = slots[rd_ptr];
  assign do_wr  = wr && !q_full;
  assign do_rd  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule
`default_nettype wire

/* hdl/rhca_back.sv */
// Back end: slot table, probe/release/cleanup sequencer, totals, aging and
// config registers. Depends on rhca_pkg and rhca_ram.
`timescale 1ns / 1ps
`default_nettype none
module rhca_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [62:0]  cfg_data,
  input  wire logic         q_empty,
  input  rhca_pkg::item_t   q_item,
  output logic              q_pop,
  output logic              busy,
  output logic              res_valid,
  output rhca_pkg::result_t res,
  input  wire logic         outq_full
);
  import rhca_pkg::*;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_CHECK, S_ADAPT1, S_ADAPT2, S_RESP
  } state_t;

  state_t              state;
  item_t               cur;
  logic [SLOT_W-1:0]   probe;
  logic [SLOT_W-1:0]   n;
  logic [15:0]         default_age;
  logic [62:0]         max_bytes;
  logic [15:0]         max_files;
  logic [63:0]         byte_total;
  logic [CNT_W-1:0]    entry_total;
  logic [AGE_W-1:0]    age_limit;
  status_t             r_status;
  logic [HANDLE_W-1:0] r_handle;
  logic [CNT_W-1:0]    evicted;
  logic [AGE_W-1:0]    shrink_age;
  logic [12:0]         floor_age;
  logic [18:0]         grow_age;
  logic [AGE_W-1:0]    ceil_age;
  logic                do_shrink;
  logic                do_grow;

  logic                ram_we;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t              rd;
  entry_t              upd;
  logic [64:0]         sum65;
  logic [63:0]         add_sat;
  logic [63:0]         sub_sat;
  logic [62:0]         age_diff;
  logic                is_old;
  logic                key_match;
  logic                handle_bad;
  logic [36:0]         prod3;
  logic [31:0]         prod10;
  logic [20:0]         prod5;

  rhca_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_SLOTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (probe),
    .wdata (upd),
    .raddr (probe),
    .rdata (ram_rdata)
  );

  assign rd         = entry_t'(ram_rdata);
  assign cfg_ready  = 1'b1;
  assign busy       = (state == S_CLEAR);
  assign q_pop      = (state == S_IDLE) && !q_empty;
  assign res_valid  = (state == S_RESP);
  assign res        = '{status: r_status, handle: r_handle, evicted: evicted,
                        active: entry_total, bytes: byte_total, age: age_limit};

  assign sum65      = {1'b0, byte_total} + {2'b0, cur.size};
  assign add_sat    = sum65[64] ? '1 : sum65[63:0];
  assign sub_sat    = (byte_total >= {1'b0, rd.size}) ? byte_total - {1'b0, rd.size} : '0;
  assign age_diff   = cur.now - rd.last;
  assign is_old     = rd.valid && (rd.refs == '0) && (cur.now >= rd.last)
                      && (age_diff >= 63'(age_limit));
  assign key_match  = (rd.inode == cur.inode) && (rd.device == cur.device)
                      && (rd.size == cur.size) && (rd.ctime == cur.ctime);
  assign handle_bad = int'(cur.handle) >= TABLE_SLOTS;
  assign prod3      = {age_limit, 1'b0} * DIV3_MUL;
  assign prod10     = default_age * DIV10_MUL;
  assign prod5      = {3'b0, age_limit} * 21'd5;

  always_comb begin
    ram_we = 1'b0;
    upd    = rd;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      upd    = '0;
    end else if (state == S_CHECK) begin
      case (cur.action)
        ACT_MAP: begin
          if (!rd.valid) begin
            ram_we     = 1'b1;
            upd.valid  = 1'b1;
            upd.inode  = cur.inode;
            upd.device = cur.device;
            upd.size   = cur.size;
            upd.ctime  = cur.ctime;
            upd.refs   = REF_BITS'(1);
            upd.last   = cur.now;
          end else if (key_match && (rd.refs != '1)) begin
            ram_we   = 1'b1;
            upd.refs = rd.refs + REF_BITS'(1);
            upd.last = cur.now;
          end
        end
        ACT_UNMAP: begin
          if (!handle_bad && rd.valid && (rd.refs != '0)) begin
            ram_we   = 1'b1;
            upd.refs = rd.refs - REF_BITS'(1);
            upd.last = cur.now;
          end
        end
        ACT_CLEAN: begin
          if (is_old) begin
            ram_we    = 1'b1;
            upd.valid = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      probe       <= '0;
      default_age <= AGE_RESET;
      max_bytes   <= BYTES_RESET;
      max_files   <= FILES_RESET;
      byte_total  <= '0;
      entry_total <= '0;
      age_limit   <= AGE_W'(AGE_RESET);
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_AGE:   default_age <= cfg_data[15:0];
          CFG_BYTES: max_bytes   <= cfg_data;
          CFG_FILES: max_files   <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          probe <= probe + SLOT_W'(1);
          if (probe == SLOT_LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!q_empty) begin
            cur      <= q_item;
            r_handle <= '0;
            evicted  <= '0;
            n        <= '0;
            case (q_item.action)
              ACT_MAP: begin
                probe <= q_item.home;
                state <= S_READ;
              end
              ACT_UNMAP: begin
                probe <= q_item.handle[SLOT_W-1:0];
                state <= S_READ;
              end
              ACT_CLEAN: begin
                probe <= '0;
                state <= S_READ;
              end
              default: begin
                r_status <= ST_NOT_FOUND;
                state    <= S_RESP;
              end
            endcase
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          case (cur.action)
            ACT_MAP: begin
              if (!rd.valid) begin
                entry_total <= entry_total + CNT_W'(1);
                byte_total  <= add_sat;
                r_status    <= ST_INSERTED;
                r_handle    <= HANDLE_W'(probe);
                state       <= S_RESP;
              end else if (key_match) begin
                if (rd.refs == '1) begin
                  r_status <= ST_OVERFLOW;
                end else begin
                  r_status <= ST_HIT;
                  r_handle <= HANDLE_W'(probe);
                end
                state <= S_RESP;
              end else if (n == SLOT_LAST) begin
                r_status <= ST_FULL;
                state    <= S_RESP;
              end else begin
                probe <= probe + SLOT_W'(1);
                n     <= n + SLOT_W'(1);
                state <= S_READ;
              end
            end
            ACT_UNMAP: begin
              if (handle_bad || !rd.valid) begin
                r_status <= ST_NOT_FOUND;
              end else if (rd.refs == '0) begin
                r_status <= ST_ZERO;
              end else begin
                r_status <= ST_HIT;
                r_handle <= cur.handle;
              end
              state <= S_RESP;
            end
            ACT_CLEAN: begin
              if (is_old) begin
                entry_total <= entry_total - CNT_W'(1);
                byte_total  <= sub_sat;
                evicted     <= evicted + CNT_W'(1);
              end
              if (probe == SLOT_LAST) begin
                state <= S_ADAPT1;
              end else begin
                probe <= probe + SLOT_W'(1);
                state <= S_READ;
              end
            end
            default: state <= S_RESP;
          endcase
        end
        S_ADAPT1: begin
          shrink_age <= prod3[36:19];
          floor_age  <= prod10[31:19];
          grow_age   <= prod5[20:2];
          ceil_age   <= AGE_W'(default_age) * AGE_W'(3);
          do_shrink  <= (byte_total > {1'b0, max_bytes})
                        || ({5'b0, entry_total} > max_files);
          do_grow    <= {5'b0, entry_total} < (max_files >> 1);
          state      <= S_ADAPT2;
        end
        S_ADAPT2: begin
          if (do_shrink) begin
            age_limit <= (shrink_age > AGE_W'(floor_age)) ? shrink_age : AGE_W'(floor_age);
          end else if (do_grow) begin
            age_limit <= (grow_age < {1'b0, ceil_age}) ? grow_age[AGE_W-1:0] : ceil_age;
          end
          r_status <= ST_CLEANED;
          state    <= S_RESP;
        end
        S_RESP: begin
          if (!outq_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_entry_bound: assert property (@(posedge clk) disable iff (rst)
    entry_total <= CNT_W'(TABLE_SLOTS))
    else $error("entry total above table size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_RESP) |-> !ram_we)
    else $error("table write outside a probe or clear");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != S_IDLE))
    else $error("request taken but sequencer stayed idle");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && outq_full) |=> (res_valid && $stable(r_status)))
    else $error("result dropped while result queue full");
endmodule
`default_nettype wire

/* hdl/refcounted_hash_cache_with_aging_top.sv */
// Top level of the refcounted hash cache with aging: front end, back end
// and result queue. Depends on rhca_pkg, rhca_front, rhca_back, rhca_outq.
//
//  channel   handshake               transfers when          payload
//  request   push / full             push && !full           action, key, now, handle
//  result    pop / empty             pop && !empty           status .. current_expire_age
//  config    cfg_valid / cfg_ready   cfg_valid && cfg_ready  cfg_index, cfg_data
//
// After reset a clearing pass writes all TABLE_SLOTS table entries, one per
// cycle; full stays high during it, config writes still land.
// Map: dequeue, then a table read and a check per slot probed (table read port).
// Unmap: a read and check of the handle's slot. Cleanup: a read and check per slot, then the age limit is adapted.
// Each side has a two-transaction queue, so either side may stall on its own.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_hash_cache_with_aging_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // request queue
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [1:0]                     action,
  input  wire logic [63:0]                    file_inode,
  input  wire logic [31:0]                    file_device,
  input  wire logic [62:0]                    file_size,
  input  wire logic [62:0]                    change_time,
  input  wire logic [62:0]                    now_seconds,
  input  wire logic [rhca_pkg::HANDLE_W-1:0]  slot_handle,
  // result queue
  output logic                                empty,
  input  wire logic                           pop,
  output logic [2:0]                          status,
  output logic [rhca_pkg::HANDLE_W-1:0]       result_handle,
  output logic [rhca_pkg::CNT_W-1:0]          evicted_count,
  output logic [rhca_pkg::CNT_W-1:0]          active_count,
  output logic [63:0]                         total_bytes,
  output logic [rhca_pkg::AGE_W-1:0]          current_expire_age,
  // config writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [62:0]                    cfg_data
);
  import rhca_pkg::*;

  logic    busy;
  logic    q_pop;
  logic    q_empty;
  item_t   q_item;
  logic    res_valid;
  result_t res;
  logic    outq_full;
  result_t head;

  // Front: hash the key on entry so the back end starts probing at once.
  rhca_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .file_inode  (file_inode),
    .file_device (file_device),
    .file_size   (file_size),
    .change_time (change_time),
    .now_seconds (now_seconds),
    .slot_handle (slot_handle),
    .busy        (busy),
    .q_pop       (q_pop),
    .q_empty     (q_empty),
    .q_item      (q_item)
  );

  // Back: one transaction at a time against the slot table.
  rhca_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .outq_full (outq_full)
  );

  // Results wait here until popped; the back end goes on meanwhile unless this queue is full.
  rhca_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_valid),
    .wr_data (res),
    .q_full  (outq_full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  assign status             = head.status;
  assign result_handle      = head.handle;
  assign evicted_count      = head.evicted;
  assign active_count       = head.active;
  assign total_bytes        = head.bytes;
  assign current_expire_age = head.age;
endmodule
`default_nettype wire
